>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> design/brtd_pkg.sv
// ----------------------------------------------------------------------------
// Track decoder package
// Types and constants shared by the run-length track decoder modules.
// ----------------------------------------------------------------------------
package brtd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 15;
  localparam int unsigned LenW   = 16;
  localparam int unsigned TotalW = 30;
  localparam int unsigned ErrW   = 3;

  localparam logic [LenW-1:0] MinRecord = 16'd3;

  // error codes carried on each result
  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT_LEN = 3'd1,
    ERR_RUN_TRUNC = 3'd2,
    ERR_LIT_BAD   = 3'd3,
    ERR_REC_CUT   = 3'd4
  } err_e;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LENHI = 6'b000010,
    PH_HDRLO = 6'b000100,
    PH_HDRHI = 6'b001000,
    PH_RUN   = 6'b010000,
    PH_LIT   = 6'b100000
  } phase_e;

  // command from the parser to the output stage
  typedef struct packed {
    logic              emit;   // produce a result beat
    logic              clear;  // zero the running total afterwards
    logic              done;   // last result of the record
    err_e              err;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage

>>> design/brtd_front.sv
// ----------------------------------------------------------------------------
// Track decoder front end
// Parses record length and block headers, one byte per beat, and turns each
// byte into at most one command for the output stage.
// ----------------------------------------------------------------------------
module brtd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [brtd_pkg::ByteW-1:0]  in_byte_i,
  input  logic                        track_start_i,
  output logic                        push_o,
  output brtd_pkg::cmd_t              cmd_o
);

  brtd_pkg::phase_e                  phase_q, phase_d;
  logic [brtd_pkg::LenW-1:0]         rem_q, rem_d;
  logic [brtd_pkg::CountW-1:0]       blk_q, blk_d;
  logic [brtd_pkg::ByteW-1:0]        hlo_q, hlo_d;

  logic [brtd_pkg::LenW-1:0]         word;
  logic [brtd_pkg::CountW-1:0]       blk_dec;
  logic [brtd_pkg::LenW:0]           lit_need;

  assign word     = {in_byte_i, hlo_q};
  assign blk_dec  = blk_q - brtd_pkg::CountW'(1);
  assign lit_need = {2'b00, word[brtd_pkg::CountW-1:0]} + 17'd2;

  // classify the byte and advance the parser
  always_comb begin
    phase_d      = phase_q;
    rem_d        = rem_q;
    blk_d        = blk_q;
    hlo_d        = hlo_q;
    push_o       = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.clear  = 1'b0;
    cmd_o.done   = 1'b0;
    cmd_o.err    = brtd_pkg::ERR_NONE;
    cmd_o.data   = in_byte_i;
    cmd_o.count  = '0;

    if (accept_i) begin
      if (track_start_i) begin
        // a new record: flag a cut record if one was open, then reset the total
        push_o      = 1'b1;
        cmd_o.clear = 1'b1;
        if (phase_q != brtd_pkg::PH_IDLE) begin
          cmd_o.emit = 1'b1;
          cmd_o.done = 1'b1;
          cmd_o.err  = brtd_pkg::ERR_REC_CUT;
          cmd_o.data = '0;
        end
        rem_d   = '0;
        blk_d   = '0;
        hlo_d   = in_byte_i;
        phase_d = brtd_pkg::PH_LENHI;
      end else begin
        unique case (phase_q)
          brtd_pkg::PH_IDLE: begin
            // drop bytes outside a record
          end
          brtd_pkg::PH_LENHI: begin
            if (word < brtd_pkg::MinRecord) begin
              push_o     = 1'b1;
              cmd_o.emit = 1'b1;
              cmd_o.done = 1'b1;
              cmd_o.err  = brtd_pkg::ERR_SHORT_LEN;
              cmd_o.data = '0;
              phase_d    = brtd_pkg::PH_IDLE;
            end else begin
              rem_d   = word;
              phase_d = brtd_pkg::PH_HDRLO;
            end
          end
          brtd_pkg::PH_HDRLO: begin
            if (rem_q < brtd_pkg::LenW'(2)) begin
              push_o     = 1'b1;
              cmd_o.emit = 1'b1;
              cmd_o.done = 1'b1;
              cmd_o.err  = brtd_pkg::ERR_REC_CUT;
              cmd_o.data = '0;
              phase_d    = brtd_pkg::PH_IDLE;
            end else begin
              hlo_d   = in_byte_i;
              phase_d = brtd_pkg::PH_HDRHI;
            end
          end
          brtd_pkg::PH_HDRHI: begin
            if (in_byte_i[brtd_pkg::ByteW-1]) begin
              // run block: count plus a single fill byte
              if (rem_q < brtd_pkg::MinRecord) begin
                push_o     = 1'b1;
                cmd_o.emit = 1'b1;
                cmd_o.done = 1'b1;
                cmd_o.err  = brtd_pkg::ERR_RUN_TRUNC;
                cmd_o.data = '0;
                phase_d    = brtd_pkg::PH_IDLE;
              end else begin
                rem_d   = rem_q - brtd_pkg::MinRecord;
                blk_d   = word[brtd_pkg::CountW-1:0];
                phase_d = brtd_pkg::PH_RUN;
              end
            end else begin
              // literal block: must be non-empty and fit in the record
              if (word[brtd_pkg::CountW-1:0] == '0 || {1'b0, rem_q} < lit_need) begin
                push_o     = 1'b1;
                cmd_o.emit = 1'b1;
                cmd_o.done = 1'b1;
                cmd_o.err  = brtd_pkg::ERR_LIT_BAD;
                cmd_o.data = '0;
                phase_d    = brtd_pkg::PH_IDLE;
              end else begin
                rem_d   = rem_q - lit_need[brtd_pkg::LenW-1:0];
                blk_d   = word[brtd_pkg::CountW-1:0];
                phase_d = brtd_pkg::PH_LIT;
              end
            end
          end
          brtd_pkg::PH_RUN: begin
            push_o      = 1'b1;
            cmd_o.emit  = 1'b1;
            cmd_o.count = blk_q;
            cmd_o.done  = (rem_q == '0);
            blk_d       = '0;
            phase_d     = (rem_q == '0) ? brtd_pkg::PH_IDLE : brtd_pkg::PH_HDRLO;
          end
          brtd_pkg::PH_LIT: begin
            push_o      = 1'b1;
            cmd_o.emit  = 1'b1;
            cmd_o.count = brtd_pkg::CountW'(1);
            blk_d       = blk_dec;
            if (blk_dec == '0) begin
              cmd_o.done = (rem_q == '0);
              phase_d    = (rem_q == '0) ? brtd_pkg::PH_IDLE : brtd_pkg::PH_HDRLO;
            end
          end
          default: begin
            phase_d = brtd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= brtd_pkg::PH_IDLE;
      rem_q   <= '0;
      blk_q   <= '0;
      hlo_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      blk_q   <= blk_d;
      hlo_q   <= hlo_d;
    end
  end

endmodule

>>> design/brtd_queue.sv
// ----------------------------------------------------------------------------
// Track decoder command queue
// Small first-in first-out buffer between parser and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brtd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brtd_pkg::cmd_t wdata_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output brtd_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  brtd_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  // advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `ASSERT_NEVER(a_push_full, push_i && full_o)
  `ASSERT_NEVER(a_pop_empty, pop_i && !valid_o)
  `ASSERT_AT(a_cnt_track, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CntW'(1)))

endmodule

>>> design/brtd_back.sv
// ----------------------------------------------------------------------------
// Track decoder output stage
// Executes queued commands: keeps the running total and holds one result
// in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brtd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  brtd_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brtd_pkg::ByteW-1:0]    out_byte_o,
  output logic [brtd_pkg::CountW-1:0]   repeat_count_o,
  output logic                          track_done_o,
  output logic [brtd_pkg::TotalW-1:0]   decoded_total_o,
  output logic [brtd_pkg::ErrW-1:0]     error_code_o
);

  logic                          valid_q, valid_d;
  logic [brtd_pkg::TotalW-1:0]   total_q, total_d;
  logic [brtd_pkg::TotalW-1:0]   sum;
  logic                          load;

  logic [brtd_pkg::ByteW-1:0]    byte_q;
  logic [brtd_pkg::CountW-1:0]   count_q;
  logic                          done_q;
  logic [brtd_pkg::TotalW-1:0]   otot_q;
  logic [brtd_pkg::ErrW-1:0]     err_q;

  assign sum   = total_q + {{(brtd_pkg::TotalW - brtd_pkg::CountW){1'b0}}, cmd_i.count};
  assign pop_o = cmd_valid_i && (!valid_q || out_ready_i);
  assign load  = pop_o && cmd_i.emit;

  // update total and output valid
  always_comb begin
    valid_d = valid_q && !out_ready_i;
    total_d = total_q;
    if (pop_o) begin
      valid_d = cmd_i.emit;
      total_d = cmd_i.clear ? '0 : (cmd_i.emit ? sum : total_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      total_q <= '0;
    end else begin
      valid_q <= valid_d;
      total_q <= total_d;
    end
  end

  // load result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= cmd_i.data;
      count_q <= cmd_i.count;
      done_q  <= cmd_i.done;
      otot_q  <= cmd_i.done ? sum : '0;
      err_q   <= cmd_i.err;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign repeat_count_o  = count_q;
  assign track_done_o    = done_q;
  assign decoded_total_o = otot_q;
  assign error_code_o    = err_q;

  `ASSERT_AT(a_total_only_done, (out_valid_o && !track_done_o) |-> (decoded_total_o == '0))
  `ASSERT_AT(a_err_ends_track, (out_valid_o && error_code_o != '0) |-> track_done_o)
  `ASSERT_AT(a_err_no_count, (out_valid_o && error_code_o != '0) |-> (repeat_count_o == '0))

endmodule

>>> design/block_rle_track_decoder_top.sv
// ----------------------------------------------------------------------------
// Run-length track decoder, top level
// Decodes compressed track records byte by byte into (byte, count) results.
// ----------------------------------------------------------------------------
// Input channel: one compressed byte per beat on in_byte_i, with
// track_start_i high on the low length byte of each record. Output channel:
// one result per decoded literal byte or run, carrying the byte and its
// repeat count; the last result of a record (or an error result) has
// track_done_o set and the record's decoded total.
// A byte is accepted every cycle while the command queue has room. A result
// passes through the command queue and then the output register after the
// byte that causes it is accepted; sustained rate is one byte per cycle
// while out_ready_i is high, set by the parser's per-byte header and counter update.
// Bytes that make no result (length and header bytes, discarded bytes) still
// pass through the queue only when they start a record.
// After an error, bytes are dropped until the next track_start_i.
// Reset clears the parser to idle, empties the queue and zeroes the total.
// When the receiver holds out_ready_i low, the result register holds, the
// queue fills up to QDepth commands, and in_ready_o then drops.
// ----------------------------------------------------------------------------
module block_rle_track_decoder_top #(
  parameter int unsigned QDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brtd_pkg::ByteW-1:0]    in_byte_i,
  input  logic                          track_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brtd_pkg::ByteW-1:0]    out_byte_o,
  output logic [brtd_pkg::CountW-1:0]   repeat_count_o,
  output logic                          track_done_o,
  output logic [brtd_pkg::TotalW-1:0]   decoded_total_o,
  output logic [brtd_pkg::ErrW-1:0]     error_code_o
);

  logic           accept;
  logic           push;
  logic           full;
  logic           q_valid;
  logic           pop;
  brtd_pkg::cmd_t push_cmd;
  brtd_pkg::cmd_t pop_cmd;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  brtd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .track_start_i (track_start_i),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  brtd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (pop_cmd)
  );

  brtd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .repeat_count_o  (repeat_count_o),
    .track_done_o    (track_done_o),
    .decoded_total_o (decoded_total_o),
    .error_code_o    (error_code_o)
  );

endmodule
